@@ sv/mbt_pkg.sv @@
// shared constants and types for the maze backtracker step core
// no dependencies; used by the channel interfaces, the controller and the top level
package mbt_pkg;

   localparam int MAX_SIDE_DEFAULT = 32;

   localparam int OP_W     = 1;
   localparam int RND_W    = 16;
   localparam int KIND_W   = 2;
   localparam int CELL_W   = 5;
   localparam int DIR_W    = 2;
   localparam int CSR_W    = 6;

   localparam logic [CSR_W-1:0] GRID_SIDE_RESET = 6'd32;

   typedef logic [KIND_W-1:0] event_kind_type;
   typedef logic [DIR_W-1:0]  dir_type;

   localparam logic [OP_W-1:0] OP_START = 1'b0;
   localparam logic [OP_W-1:0] OP_STEP  = 1'b1;

   localparam event_kind_type EV_STARTED     = 2'd0;
   localparam event_kind_type EV_CARVED      = 2'd1;
   localparam event_kind_type EV_BACKTRACKED = 2'd2;
   localparam event_kind_type EV_FINISHED    = 2'd3;

   localparam dir_type DIR_TOP    = 2'd0;
   localparam dir_type DIR_BOTTOM = 2'd1;
   localparam dir_type DIR_LEFT   = 2'd2;
   localparam dir_type DIR_RIGHT  = 2'd3;

endpackage

@@ sv/mbt_if.sv @@
// valid/ready channel interfaces for the step requests and the event responses
// depends on mbt_pkg for the field widths
interface mbt_req_if;
   logic                         valid;
   logic                         ready;
   logic [mbt_pkg::OP_W-1:0]     op;
   logic [mbt_pkg::RND_W-1:0]    random_value;

   modport source (output valid, output op, output random_value, input ready);
   modport sink   (input valid, input op, input random_value, output ready);
endinterface

interface mbt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mbt_pkg::KIND_W-1:0]   event_kind;
   logic [mbt_pkg::CELL_W-1:0]   cell_x;
   logic [mbt_pkg::CELL_W-1:0]   cell_y;
   logic [mbt_pkg::DIR_W-1:0]    carve_direction;

   modport source (output valid, output event_kind, output cell_x, output cell_y,
                   output carve_direction, input ready);
   modport sink   (input valid, input event_kind, input cell_x, input cell_y,
                   input carve_direction, output ready);
endinterface

@@ sv/mbt_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
module mbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/mbt_ctrl.sv @@
// step sequencer: reads the visited rows around the current cell and the stack top,
// decides carve / backtrack / finish and writes back; depends on mbt_pkg and mbt_if
module mbt_ctrl #(
   parameter int MAX_SIDE = mbt_pkg::MAX_SIDE_DEFAULT,
   localparam int CW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
   localparam int SW  = ($clog2(MAX_SIDE + 1) > mbt_pkg::CSR_W) ?
                        $clog2(MAX_SIDE + 1) : mbt_pkg::CSR_W,
   localparam int CELLS = MAX_SIDE * MAX_SIDE,
   localparam int SAW = $clog2(CELLS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [SW-1:0]       side,
   mbt_req_if.sink             req,
   mbt_rsp_if.source           rsp,
   output logic                vis_we,
   output logic [CW-1:0]       vis_waddr,
   output logic [MAX_SIDE-1:0] vis_wdata,
   output logic                vis_re,
   output logic [CW-1:0]       vis_raddr,
   input  logic [MAX_SIDE-1:0] vis_rdata,
   output logic                stk_we,
   output logic [SAW-1:0]      stk_waddr,
   output logic [2*CW-1:0]     stk_wdata,
   output logic                stk_re,
   output logic [SAW-1:0]      stk_raddr,
   input  logic [2*CW-1:0]     stk_rdata
);

   localparam int DW = $clog2(CELLS + 1);
   localparam int STW = 3;

   localparam logic [STW-1:0] S_CLEAR  = 3'd0;
   localparam logic [STW-1:0] S_IDLE   = 3'd1;
   localparam logic [STW-1:0] S_MID    = 3'd2;
   localparam logic [STW-1:0] S_DOWN   = 3'd3;
   localparam logic [STW-1:0] S_DECIDE = 3'd4;
   localparam logic [STW-1:0] S_POST   = 3'd5;

   localparam logic [CW-1:0] LAST_COORD = CW'(MAX_SIDE - 1);
   localparam logic [DW-1:0] DEPTH_FULL = DW'(CELLS);

   // value mod 3 by folding base-4 digits
   function automatic logic [1:0] mod3(input logic [mbt_pkg::RND_W-1:0] v);
      logic [4:0] s1;
      logic [3:0] s2;
      logic [2:0] s3;
      s1 = '0;
      for (int i = 0; i < mbt_pkg::RND_W / 2; i++) begin
         s1 = s1 + 5'(v[2*i +: 2]);
      end
      s2 = 4'(s1[4:2]) + 4'(s1[1:0]);
      s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
      if (s3 >= 3'd3) begin
         s3 = s3 - 3'd3;
      end
      return s3[1:0];
   endfunction

   // position of the k-th set bit of a four bit mask
   function automatic mbt_pkg::dir_type nth_set(input logic [3:0] mask, input logic [1:0] k);
      logic [2:0]      seen;
      mbt_pkg::dir_type pos;
      seen = '0;
      pos  = mbt_pkg::DIR_TOP;
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            if (seen == {1'b0, k}) begin
               pos = mbt_pkg::dir_type'(i);
            end
            seen = seen + 3'd1;
         end
      end
      return pos;
   endfunction

   logic [STW-1:0]      state_ff, state_in;
   logic [CW-1:0]       row_ff, row_in;
   logic                clr_start_ff, clr_start_in;
   logic                active_ff, active_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [CW-1:0]       cur_x_ff, cur_x_in;
   logic [CW-1:0]       cur_y_ff, cur_y_in;
   mbt_pkg::event_kind_type kind_ff, kind_in;
   logic [1:0]          rnd_m3_ff, rnd_m3_in;
   logic [1:0]          rnd_lo_ff, rnd_lo_in;
   logic [MAX_SIDE-1:0] up_ff, up_in;
   logic [MAX_SIDE-1:0] mid_ff, mid_in;

   logic                rsp_valid_ff, rsp_valid_in;
   mbt_pkg::event_kind_type rsp_kind_ff, rsp_kind_in;
   logic [mbt_pkg::CELL_W-1:0] rsp_x_ff, rsp_x_in;
   logic [mbt_pkg::CELL_W-1:0] rsp_y_ff, rsp_y_in;
   mbt_pkg::dir_type    rsp_dir_ff, rsp_dir_in;

   logic                accept;
   logic                out_free;
   logic [SW-1:0]       xe, ye;
   logic [CW-1:0]       x_left, x_right;
   logic [CW-1:0]       up_addr, down_addr;
   logic [3:0]          avail;
   logic [2:0]          count;
   logic [1:0]          k;
   mbt_pkg::dir_type    pick;
   logic [CW-1:0]       nx, ny;
   logic [MAX_SIDE-1:0] new_row_src;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);

   assign xe = SW'(cur_x_ff);
   assign ye = SW'(cur_y_ff);
   assign x_left  = cur_x_ff - CW'(1);
   assign x_right = (cur_x_ff == LAST_COORD) ? cur_x_ff : cur_x_ff + CW'(1);
   assign up_addr   = (cur_y_ff == '0) ? cur_y_ff : cur_y_ff - CW'(1);
   assign down_addr = (cur_y_ff == LAST_COORD) ? cur_y_ff : cur_y_ff + CW'(1);

   // neighbours in the order top, bottom, left, right; down row is the ram output
   always_comb begin
      avail[0] = (cur_y_ff != '0) && ((ye - SW'(1)) < side) && (xe < side) &&
                 !up_ff[cur_x_ff];
      avail[1] = ((ye + SW'(1)) < side) && (xe < side) && !vis_rdata[cur_x_ff];
      avail[2] = (cur_x_ff != '0) && ((xe - SW'(1)) < side) && (ye < side) &&
                 !mid_ff[x_left];
      avail[3] = ((xe + SW'(1)) < side) && (ye < side) && !mid_ff[x_right];
      count = 3'($countones(avail));
      unique case (count)
         3'd2:    k = {1'b0, rnd_lo_ff[0]};
         3'd3:    k = rnd_m3_ff;
         3'd4:    k = rnd_lo_ff;
         default: k = 2'd0;
      endcase
      pick = nth_set(avail, k);
      nx = cur_x_ff;
      ny = cur_y_ff;
      new_row_src = mid_ff;
      unique case (pick)
         mbt_pkg::DIR_TOP: begin
            ny = up_addr;
            new_row_src = up_ff;
         end
         mbt_pkg::DIR_BOTTOM: begin
            ny = down_addr;
            new_row_src = vis_rdata;
         end
         mbt_pkg::DIR_LEFT:  nx = x_left;
         mbt_pkg::DIR_RIGHT: nx = x_right;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      clr_start_in = clr_start_ff;
      active_in    = active_ff;
      depth_in     = depth_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      kind_in      = kind_ff;
      rnd_m3_in    = rnd_m3_ff;
      rnd_lo_in    = rnd_lo_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_dir_in   = rsp_dir_ff;

      vis_we    = 1'b0;
      vis_waddr = row_ff;
      vis_wdata = '0;
      vis_re    = 1'b0;
      vis_raddr = up_addr;
      stk_we    = 1'b0;
      stk_waddr = depth_ff[SAW-1:0];
      stk_wdata = {cur_y_ff, cur_x_ff};
      stk_re    = 1'b0;
      stk_raddr = SAW'(depth_ff - DW'(1));

      unique case (state_ff)
         S_CLEAR: begin
            vis_we = 1'b1;
            // a start leaves the origin marked visited
            if (clr_start_ff && row_ff == '0) begin
               vis_wdata = MAX_SIDE'(1);
            end
            row_in = row_ff + CW'(1);
            if (row_ff == LAST_COORD) begin
               row_in   = '0;
               state_in = clr_start_ff ? S_POST : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req.op == mbt_pkg::OP_START) begin
                  clr_start_in = 1'b1;
                  row_in       = '0;
                  active_in    = 1'b1;
                  depth_in     = '0;
                  cur_x_in     = '0;
                  cur_y_in     = '0;
                  kind_in      = mbt_pkg::EV_STARTED;
                  state_in     = S_CLEAR;
               end else if (!active_ff) begin
                  kind_in  = mbt_pkg::EV_FINISHED;
                  state_in = S_POST;
               end else begin
                  vis_re    = 1'b1;
                  stk_re    = 1'b1;
                  rnd_m3_in = mod3(req.random_value);
                  rnd_lo_in = req.random_value[1:0];
                  state_in  = S_MID;
               end
            end
         end
         S_MID: begin
            up_in     = vis_rdata;
            vis_re    = 1'b1;
            vis_raddr = cur_y_ff;
            state_in  = S_DOWN;
         end
         S_DOWN: begin
            mid_in    = vis_rdata;
            vis_re    = 1'b1;
            vis_raddr = down_addr;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            // ram outputs hold while waiting for the response slot
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dir_in   = mbt_pkg::DIR_TOP;
               rsp_x_in     = mbt_pkg::CELL_W'(cur_x_ff);
               rsp_y_in     = mbt_pkg::CELL_W'(cur_y_ff);
               state_in     = S_IDLE;
               if (count != 3'd0) begin
                  rsp_kind_in = mbt_pkg::EV_CARVED;
                  rsp_dir_in  = pick;
                  if (depth_ff != DEPTH_FULL) begin
                     stk_we   = 1'b1;
                     depth_in = depth_ff + DW'(1);
                  end
                  vis_we    = 1'b1;
                  vis_waddr = ny;
                  vis_wdata = new_row_src | (MAX_SIDE'(1) << nx);
                  cur_x_in  = nx;
                  cur_y_in  = ny;
               end else if (depth_ff != '0) begin
                  rsp_kind_in = mbt_pkg::EV_BACKTRACKED;
                  depth_in    = depth_ff - DW'(1);
                  cur_x_in    = stk_rdata[CW-1:0];
                  cur_y_in    = stk_rdata[2*CW-1:CW];
                  rsp_x_in    = mbt_pkg::CELL_W'(stk_rdata[CW-1:0]);
                  rsp_y_in    = mbt_pkg::CELL_W'(stk_rdata[2*CW-1:CW]);
               end else begin
                  rsp_kind_in = mbt_pkg::EV_FINISHED;
                  active_in   = 1'b0;
               end
            end
         end
         S_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_x_in     = mbt_pkg::CELL_W'(cur_x_ff);
               rsp_y_in     = mbt_pkg::CELL_W'(cur_y_ff);
               rsp_dir_in   = mbt_pkg::DIR_TOP;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= '0;
         clr_start_ff <= 1'b0;
         active_ff    <= 1'b0;
         depth_ff     <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         clr_start_ff <= clr_start_in;
         active_ff    <= active_in;
         depth_ff     <= depth_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      rnd_m3_ff   <= rnd_m3_in;
      rnd_lo_ff   <= rnd_lo_in;
      up_ff       <= up_in;
      mid_ff      <= mid_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_dir_ff  <= rsp_dir_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.event_kind      = rsp_kind_ff;
   assign rsp.cell_x          = rsp_x_ff;
   assign rsp.cell_y          = rsp_y_ff;
   assign rsp.carve_direction = rsp_dir_ff;

endmodule

@@ sv/maze_backtracker_step_core.sv @@
// top level of the maze backtracker step core: side register, row and stack memories
// depends on mbt_pkg, mbt_if, mbt_ram and mbt_ctrl
//
// Randomized depth-first maze generator, one step per request. The visited map is
// kept as one row of MAX_SIDE bits per memory word and the backtrack stack in a
// second memory. A step request is done before the next one is taken: the rows
// above, at and below the current cell are read one after the other through the
// single read port of the row memory, then the decision state, which waits while
// the response register is full, writes back the carved row and the stack. A start
// request clears the whole map one row per cycle; a step while no maze is active
// answers finished without a memory read. After reset the same clearing pass runs
// over every row before the first request is taken. A finished response sits in an
// output register, so the next request can be taken while it waits.
module maze_backtracker_step_core #(
   parameter int MAX_SIDE = mbt_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [mbt_pkg::CSR_W-1:0] csr_wdata,
   mbt_req_if.sink                   req_ch,
   mbt_rsp_if.source                 rsp_ch
);

   localparam int CW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SW  = ($clog2(MAX_SIDE + 1) > mbt_pkg::CSR_W) ?
                        $clog2(MAX_SIDE + 1) : mbt_pkg::CSR_W;
   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int SAW = $clog2(CELLS);

   logic [mbt_pkg::CSR_W-1:0] grid_side_ff, grid_side_in;
   logic [SW-1:0]             side_raw;
   logic [SW-1:0]             side;

   logic                vis_we, vis_re;
   logic [CW-1:0]       vis_waddr, vis_raddr;
   logic [MAX_SIDE-1:0] vis_wdata, vis_rdata;
   logic                stk_we, stk_re;
   logic [SAW-1:0]      stk_waddr, stk_raddr;
   logic [2*CW-1:0]     stk_wdata, stk_rdata;

   assign grid_side_in = csr_we ? csr_wdata : grid_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= mbt_pkg::GRID_SIDE_RESET;
      end else begin
         grid_side_ff <= grid_side_in;
      end
   end

   // clamp the programmed side into 2 .. MAX_SIDE
   assign side_raw = SW'(grid_side_ff);
   always_comb begin
      priority if (side_raw > SW'(MAX_SIDE)) begin
         side = SW'(MAX_SIDE);
      end else if (side_raw < SW'(2)) begin
         side = SW'(2);
      end else begin
         side = side_raw;
      end
   end

   mbt_ram #(
      .WIDTH (MAX_SIDE),
      .DEPTH (MAX_SIDE)
   ) u_visited_ram (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (vis_wdata),
      .re    (vis_re),
      .raddr (vis_raddr),
      .rdata (vis_rdata)
   );

   mbt_ram #(
      .WIDTH (2 * CW),
      .DEPTH (CELLS)
   ) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   mbt_ctrl #(
      .MAX_SIDE (MAX_SIDE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .side      (side),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .vis_we    (vis_we),
      .vis_waddr (vis_waddr),
      .vis_wdata (vis_wdata),
      .vis_re    (vis_re),
      .vis_raddr (vis_raddr),
      .vis_rdata (vis_rdata),
      .stk_we    (stk_we),
      .stk_waddr (stk_waddr),
      .stk_wdata (stk_wdata),
      .stk_re    (stk_re),
      .stk_raddr (stk_raddr),
      .stk_rdata (stk_rdata)
   );

endmodule
